>>> hw/rtl/tcw_pkg.sv
// Shared types, constants and helpers for the text console writer.
// Used by tcw_cursor and text_console_writer; depends on nothing else.
package tcw_pkg;

   // Screen geometry
   localparam int WIDTH   = 80;
   localparam int HEIGHT  = 25;
   localparam int CELLS   = WIDTH * HEIGHT;
   localparam int CELL_AW = $clog2(CELLS);
   localparam int ROW_W   = $clog2(HEIGHT + 1);
   localparam int COL_W   = $clog2(WIDTH + 1);
   localparam int OFS_W   = $clog2((HEIGHT + 1) * WIDTH + 1);

   // Fixed field widths
   localparam int OFFSET_W = 11;
   localparam int INDEX_W  = 11;

   // Character and attribute codes
   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   localparam logic [7:0] SPACE_CODE   = 8'h20;
   localparam logic [7:0] RESET_COLOR  = 8'h07;

   // Operation codes
   localparam logic [1:0] OP_PUT   = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   typedef struct packed {
      logic [1:0]         op;
      logic [7:0]         char_code;
      logic [INDEX_W-1:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] cursor_offset;
      logic                cursor_write;
      logic [15:0]         cell_entry;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_SCROLL,
      ST_BLANK,
      ST_CLEAR,
      ST_REPLY
   } state_type;

   // Cursor update requests from the sequencer
   typedef enum logic [1:0] {
      CUR_HOLD,
      CUR_WRAP,
      CUR_SCROLLED,
      CUR_PUT
   } cur_cmd_type;

   typedef struct packed {
      logic                need_scroll;
      logic                newline;
      logic [CELL_AW-1:0]  wr_addr;
      logic [OFFSET_W-1:0] offset;
   } cur_status_type;

   // Screen cell: attribute in the high byte, character in the low byte
   function automatic logic [15:0] make_cell(input logic [7:0] color,
                                             input logic [7:0] ch);
      make_cell = {color, ch};
   endfunction

endpackage

>>> hw/rtl/text_console_writer.sv
// Text console writer top level: screen memory and operation sequencer.
// Depends on tcw_pkg and tcw_cursor.
//
// Usage: requests arrive on req_* (valid/ready, one tcw_pkg::req_type per
// transfer) and every request gives exactly one result on rsp_*
// (valid/ready, tcw_pkg::rsp_type). The attribute byte is written on
// csr_* and is always ready; change it only while the block is idle.
// Flow: one request is handled at a time. A plain put registers its
// result in ST_EXEC and returns to ST_IDLE; a read or an unused code
// passes through ST_EXEC and registers its result in ST_REPLY. A put
// that scrolls first runs ST_SCROLL, which moves rows up, and ST_BLANK,
// which blanks the last row; a clear writes CELLS blank cells in ST_CLEAR
// before ST_REPLY. Both go through the single write port of the screen
// memory, which the scroll copies through one cell per cycle.
// Reset: the cursor goes to the top left corner, the attribute to 7, and
// a clearing pass writes CELLS (2000) blank cells, one per cycle, with
// req_ready low meanwhile.
// Stall: a finished result sits in the output register until taken; the
// next request is still accepted, and its result waits for the slot.
module text_console_writer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tcw_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tcw_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [7:0]       csr_data
);

   localparam logic [tcw_pkg::CELL_AW-1:0] LAST_CELL =
      tcw_pkg::CELL_AW'(tcw_pkg::CELLS - 1);
   localparam logic [tcw_pkg::CELL_AW-1:0] LAST_MOVE =
      tcw_pkg::CELL_AW'(tcw_pkg::CELLS - tcw_pkg::WIDTH - 1);
   localparam logic [tcw_pkg::CELL_AW-1:0] FIRST_LAST_ROW =
      tcw_pkg::CELL_AW'(tcw_pkg::CELLS - tcw_pkg::WIDTH);

   tcw_pkg::state_type       state_ff, state_in;
   tcw_pkg::req_type         req_ff, req_in;
   tcw_pkg::rsp_type         rsp_ff, rsp_data;
   logic                     rsp_valid_ff, rsp_valid_in, rsp_load, slot_free;
   logic [7:0]               color_ff;
   logic [tcw_pkg::CELL_AW-1:0] ptr_ff, ptr_in;
   logic                     pend_ff, pend_in;
   logic [tcw_pkg::CELL_AW-1:0] pend_addr_ff, pend_addr_in;
   logic [15:0]              rdata_ff;
   logic                     in_range, entry_ok;
   tcw_pkg::cur_cmd_type     cur_cmd;
   tcw_pkg::cur_status_type  cur;

   // Memory port controls
   logic                        mem_we, mem_re;
   logic [tcw_pkg::CELL_AW-1:0] mem_waddr, mem_raddr;
   logic [15:0]                 mem_wdata;
   logic [15:0]                 screen_mem [tcw_pkg::CELLS];

   tcw_cursor u_cursor (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cur_cmd),
      .char_code (req_ff.char_code),
      .status    (cur)
   );

   assign csr_ready   = 1'b1;
   assign req_ready   = (state_ff == tcw_pkg::ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign slot_free   = !rsp_valid_ff || rsp_ready;
   assign in_range    = ({1'b0, req_ff.cell_index} < 12'(tcw_pkg::CELLS));
   assign entry_ok    = (req_ff.op == tcw_pkg::OP_READ) && in_range;

   // Sequencer: next state, memory port and cursor commands
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      ptr_in       = ptr_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      cur_cmd      = tcw_pkg::CUR_HOLD;
      mem_we       = pend_ff;
      mem_waddr    = pend_addr_ff;
      mem_wdata    = tcw_pkg::make_cell(color_ff, rdata_ff[7:0]);
      mem_re       = 1'b0;
      mem_raddr    = ptr_ff + tcw_pkg::CELL_AW'(tcw_pkg::WIDTH);
      rsp_load     = 1'b0;
      rsp_data.cursor_offset = cur.offset;
      rsp_data.cursor_write  = 1'b0;
      rsp_data.cell_entry    = '0;
      unique case (state_ff)
         tcw_pkg::ST_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            mem_wdata = tcw_pkg::make_cell(tcw_pkg::RESET_COLOR, tcw_pkg::SPACE_CODE);
            if (ptr_ff == LAST_CELL) begin
               ptr_in   = '0;
               state_in = tcw_pkg::ST_IDLE;
            end else begin
               ptr_in = ptr_ff + tcw_pkg::CELL_AW'(1);
            end
         end
         tcw_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               state_in = tcw_pkg::ST_EXEC;
            end
         end
         tcw_pkg::ST_EXEC: begin
            unique case (req_ff.op)
               tcw_pkg::OP_PUT: begin
                  if (cur.need_scroll) begin
                     cur_cmd  = tcw_pkg::CUR_WRAP;
                     ptr_in   = '0;
                     state_in = tcw_pkg::ST_SCROLL;
                  end else if (slot_free) begin
                     cur_cmd   = tcw_pkg::CUR_PUT;
                     mem_we    = !cur.newline;
                     mem_waddr = cur.wr_addr;
                     mem_wdata = tcw_pkg::make_cell(color_ff, req_ff.char_code);
                     rsp_load  = 1'b1;
                     rsp_data.cursor_write = !cur.newline;
                     state_in  = tcw_pkg::ST_IDLE;
                  end
               end
               tcw_pkg::OP_CLEAR: begin
                  ptr_in   = '0;
                  state_in = tcw_pkg::ST_CLEAR;
               end
               tcw_pkg::OP_READ: begin
                  mem_re    = in_range;
                  mem_raddr = tcw_pkg::CELL_AW'(req_ff.cell_index);
                  state_in  = tcw_pkg::ST_REPLY;
               end
               tcw_pkg::OP_NONE: begin
                  state_in = tcw_pkg::ST_REPLY;
               end
               default: state_in = tcw_pkg::ST_REPLY;
            endcase
         end
         // Read cell ptr+WIDTH; its character is written to ptr next cycle
         tcw_pkg::ST_SCROLL: begin
            mem_re       = 1'b1;
            pend_in      = 1'b1;
            pend_addr_in = ptr_ff;
            if (ptr_ff == LAST_MOVE) begin
               ptr_in   = FIRST_LAST_ROW;
               state_in = tcw_pkg::ST_BLANK;
            end else begin
               ptr_in = ptr_ff + tcw_pkg::CELL_AW'(1);
            end
         end
         // Blank the last row once the final moved cell has been written
         tcw_pkg::ST_BLANK: begin
            if (!pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = ptr_ff;
               mem_wdata = tcw_pkg::make_cell(color_ff, tcw_pkg::SPACE_CODE);
               if (ptr_ff == LAST_CELL) begin
                  cur_cmd  = tcw_pkg::CUR_SCROLLED;
                  state_in = tcw_pkg::ST_EXEC;
               end else begin
                  ptr_in = ptr_ff + tcw_pkg::CELL_AW'(1);
               end
            end
         end
         tcw_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            mem_wdata = tcw_pkg::make_cell(color_ff, tcw_pkg::SPACE_CODE);
            if (ptr_ff == LAST_CELL) begin
               state_in = tcw_pkg::ST_REPLY;
            end else begin
               ptr_in = ptr_ff + tcw_pkg::CELL_AW'(1);
            end
         end
         tcw_pkg::ST_REPLY: begin
            if (slot_free) begin
               rsp_load            = 1'b1;
               rsp_data.cell_entry = entry_ok ? rdata_ff : '0;
               state_in            = tcw_pkg::ST_IDLE;
            end
         end
         default: state_in = tcw_pkg::ST_IDLE;
      endcase
   end

   // Output slot
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcw_pkg::ST_INIT;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         color_ff     <= tcw_pkg::RESET_COLOR;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            color_ff <= csr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      pend_addr_ff <= pend_addr_in;
      if (rsp_load) begin
         rsp_ff <= rsp_data;
      end
   end

   // Screen memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= screen_mem[mem_raddr];
      end
   end

endmodule

>>> hw/rtl/tcw_cursor.sv
// Cursor row/column registers with wrap, scroll and newline handling.
// Depends on tcw_pkg for geometry, command and status types.
module tcw_cursor (
   input  logic                    clock,
   input  logic                    reset,
   input  tcw_pkg::cur_cmd_type    cmd,
   input  logic [7:0]              char_code,
   output tcw_pkg::cur_status_type status
);

   logic [tcw_pkg::ROW_W-1:0] row_ff, row_in, row_w, row_p;
   logic [tcw_pkg::COL_W-1:0] col_ff, col_in, col_w, col_p;
   logic                      wrap;
   logic                      newline;
   logic [tcw_pkg::OFS_W-1:0] wr_full;
   logic [tcw_pkg::OFS_W-1:0] ofs_full;

   // Wrap at full width, then scroll test, then the character itself
   always_comb begin
      wrap    = (col_ff >= tcw_pkg::COL_W'(tcw_pkg::WIDTH));
      row_w   = wrap ? row_ff + tcw_pkg::ROW_W'(1) : row_ff;
      col_w   = wrap ? '0 : col_ff;
      newline = (char_code == tcw_pkg::NEWLINE_CODE);
      row_p   = newline ? row_w + tcw_pkg::ROW_W'(1) : row_w;
      col_p   = newline ? '0 : col_w + tcw_pkg::COL_W'(1);
   end

   // Next cursor value
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      unique case (cmd)
         tcw_pkg::CUR_HOLD: begin
            row_in = row_ff;
            col_in = col_ff;
         end
         tcw_pkg::CUR_WRAP: begin
            row_in = row_w;
            col_in = col_w;
         end
         tcw_pkg::CUR_SCROLLED: begin
            row_in = tcw_pkg::ROW_W'(tcw_pkg::HEIGHT - 1);
            col_in = col_ff;
         end
         tcw_pkg::CUR_PUT: begin
            row_in = row_p;
            col_in = col_p;
         end
         default: begin
            row_in = row_ff;
            col_in = col_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // Cell address of the character write and offset after the update
   always_comb begin
      wr_full  = tcw_pkg::OFS_W'(row_w) * tcw_pkg::OFS_W'(tcw_pkg::WIDTH)
                 + tcw_pkg::OFS_W'(col_w);
      ofs_full = tcw_pkg::OFS_W'(row_in) * tcw_pkg::OFS_W'(tcw_pkg::WIDTH)
                 + tcw_pkg::OFS_W'(col_in);
      status.need_scroll = (row_w >= tcw_pkg::ROW_W'(tcw_pkg::HEIGHT));
      status.newline     = newline;
      status.wr_addr     = tcw_pkg::CELL_AW'(wr_full);
      status.offset      = tcw_pkg::OFFSET_W'(ofs_full);
   end

endmodule

>>> tb/sv/text_console_writer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for text_console_writer: directed and random console traffic,
// with every result checked against a screen/cursor predictor held in a scoreboard class.
// Depends on tcw_pkg and the text_console_writer RTL.
module text_console_writer_tb;
   import tcw_pkg::*;

   // Screen and cursor predictor with the queue of replies still owed by the block
   class console_model;
      logic [7:0]  color;
      int unsigned row;
      int unsigned column;
      logic [15:0] cells [CELLS];
      rsp_type     expected_replies [$];
      int          error_count;

      function new();
         color = RESET_COLOR;
         row = 0;
         column = 0;
         error_count = 0;
         blank_screen();
      endfunction

      function void set_color(logic [7:0] value);
         color = value;
      endfunction

      // writes outside the screen are dropped
      function void put_cell(int unsigned r, int unsigned c, logic [7:0] ch);
         int unsigned idx;
         idx = r * WIDTH + c;
         if (idx < CELLS) cells[idx] = {color, ch};
      endfunction

      function void blank_screen();
         for (int i = 0; i < CELLS; i++) cells[i] = {color, SPACE_CODE};
      endfunction

      // moved cells keep the character only and take the current color
      function void scroll_up();
         for (int r = 1; r < HEIGHT; r++)
            for (int c = 0; c < WIDTH; c++)
               put_cell(r - 1, c, cells[r * WIDTH + c][7:0]);
         for (int c = 0; c < WIDTH; c++) put_cell(HEIGHT - 1, c, SPACE_CODE);
      endfunction

      // apply one accepted request and queue the reply it owes
      function void note_request(req_type item);
         rsp_type reply;
         reply = '0;
         case (item.op)
            OP_PUT: begin
               if (column >= WIDTH) begin
                  row++;
                  column = 0;
               end
               if (row >= HEIGHT) begin
                  scroll_up();
                  row = HEIGHT - 1;
               end
               if (item.char_code == NEWLINE_CODE) begin
                  row++;
                  column = 0;
               end else begin
                  put_cell(row, column, item.char_code);
                  column++;
                  reply.cursor_write = 1'b1;
               end
            end
            OP_CLEAR: blank_screen();
            OP_READ: begin
               if (item.cell_index < CELLS) reply.cell_entry = cells[item.cell_index];
            end
            default: ;
         endcase
         reply.cursor_offset = OFFSET_W'(row * WIDTH + column);
         expected_replies.push_back(reply);
      endfunction

      function void check_reply(rsp_type got);
         rsp_type want;
         if (expected_replies.size() == 0) begin
            $error("reply with no request outstanding: %h", got);
            error_count++;
            return;
         end
         want = expected_replies.pop_front();
         if (got.cursor_offset !== want.cursor_offset) begin
            $error("cursor_offset: expected %0d, got %0d", want.cursor_offset,
                   got.cursor_offset);
            error_count++;
         end
         if (got.cursor_write !== want.cursor_write) begin
            $error("cursor_write: expected %0d, got %0d", want.cursor_write,
                   got.cursor_write);
            error_count++;
         end
         if (got.cell_entry !== want.cell_entry) begin
            $error("cell_entry: expected %h, got %h", want.cell_entry, got.cell_entry);
            error_count++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_payload = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_payload;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_data = '0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_cycles_left = 0;

   console_model screen_model;

   always #1 clock = ~clock;

   text_console_writer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   // Watch all three channels; a request is noted before any reply of the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) screen_model.set_color(csr_data);
         if (req_valid && req_ready) screen_model.note_request(req_payload);
         if (rsp_valid && rsp_ready) screen_model.check_reply(rsp_payload);
      end
   end

   // Reply side: random stalls, plus a long hold-off when one is requested
   initial begin
      forever begin
         @(posedge clock);
         if (hold_cycles_left > 0) begin
            rsp_ready <= 1'b0;
            hold_cycles_left--;
         end else begin
            rsp_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
         end
      end
   end

   function automatic req_type make_req(logic [1:0] op, logic [7:0] ch, int idx);
      req_type item;
      item.op = op;
      item.char_code = ch;
      item.cell_index = INDEX_W'(idx);
      return item;
   endfunction

   // valid is only lowered when the sender decides to idle
   task automatic send_request(input req_type item);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_put(input logic [7:0] ch);
      send_request(make_req(OP_PUT, ch, $urandom_range(2047, 0)));
   endtask

   task automatic send_op(input logic [1:0] op, input int idx);
      send_request(make_req(op, 8'($urandom_range(255, 0)), idx));
   endtask

   task automatic write_color(input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // stop offering and wait until every owed reply has arrived
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (screen_model.expected_replies.size() != 0) @(posedge clock);
   endtask

   // Mostly text lines of random content ending in newlines, with reads mixed in;
   // long lines exercise the wrap, newline runs push the cursor into scrolling.
   task automatic run_traffic(input int count);
      int sent;
      int kind;
      int len;
      int target;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(99, 0);
         if (kind < 55) begin
            len = ($urandom_range(3, 0) == 0) ? $urandom_range(90, 75) : $urandom_range(15, 0);
            repeat (len) begin
               send_put(8'($urandom_range(255, 0)));
               sent++;
            end
            if ($urandom_range(4, 0) != 0) begin
               send_put(NEWLINE_CODE);
               sent++;
            end
         end else if (kind < 75) begin
            // reads near the cursor, anywhere, or past the end of the screen
            case ($urandom_range(9, 0))
               0: target = $urandom_range(2047, CELLS);
               1, 2, 3, 4: begin
                  target = screen_model.row * WIDTH + screen_model.column
                           - $urandom_range(3, 0);
                  if (target < 0) target = 0;
               end
               default: target = $urandom_range(CELLS - 1, 0);
            endcase
            send_op(OP_READ, target);
            sent++;
         end else if (kind < 90) begin
            repeat ($urandom_range(4, 1)) begin
               send_put(NEWLINE_CODE);
               sent++;
            end
         end else if (kind < 92) begin
            send_op(OP_CLEAR, $urandom_range(2047, 0));
            sent++;
         end else if (kind < 97) begin
            send_op(OP_NONE, $urandom_range(2047, 0));
            sent++;
         end else begin
            // noise: any code with any content
            send_request(make_req(2'($urandom_range(3, 0)), 8'($urandom_range(255, 0)),
                                  $urandom_range(2047, 0)));
            sent++;
         end
      end
   endtask

   // Main sequence
   initial begin
      screen_model = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: reset contents, read range ends, high bytes, newline, clear, unused code
      send_op(OP_READ, 0);
      send_op(OP_READ, CELLS - 1);
      send_op(OP_READ, CELLS);
      send_op(OP_READ, 2047);
      send_op(OP_NONE, 0);
      send_put(8'h41);
      send_put(8'h80);
      send_put(8'hFF);
      send_put(8'h00);
      send_put(8'h7F);
      send_put(NEWLINE_CODE);
      send_put(SPACE_CODE);
      send_op(OP_READ, 0);
      send_op(OP_READ, 1);
      send_op(OP_READ, 2);
      send_op(OP_READ, 3);
      send_op(OP_READ, 4);
      send_op(OP_READ, WIDTH);
      send_op(OP_READ, WIDTH + 1);
      send_op(OP_CLEAR, 0);
      send_op(OP_READ, 0);
      send_op(OP_READ, WIDTH);
      send_put(NEWLINE_CODE);
      drain();

      // no idling, with one long reply hold-off so the block backs up
      write_color(8'hFF);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_cycles_left = 300;
      run_traffic(250);
      drain();

      write_color(8'h00);
      send_idle_pct = 64;
      recv_stall_pct = 0;
      run_traffic(250);
      drain();

      write_color(8'($urandom_range(255, 0)));
      send_idle_pct = 0;
      recv_stall_pct = 64;
      run_traffic(250);
      drain();

      write_color(8'($urandom_range(255, 0)));
      send_idle_pct = 11;
      recv_stall_pct = 11;
      run_traffic(250);
      drain();

      repeat (20) @(posedge clock);
      if (screen_model.error_count == 0) $display("text_console_writer_tb passed");
      else $display("text_console_writer_tb failed");
      $finish;
   end

   // Watchdog
   initial begin
      #20_000_000;
      $display("text_console_writer_tb failed");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_cursor.sv
hw/rtl/text_console_writer.sv
tb/sv/text_console_writer_tb.sv
